// ===== hw/rtl/msb_first_bit_reader_unit_macros.svh =====
// assertion macros shared by the bit reader modules
`ifndef MSB_FIRST_BIT_READER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_READER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define MFBR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bit reader check failed");

// next-cycle implication, checked on clk while out of reset
`define MFBR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bit reader check failed");

`endif

// ===== hw/rtl/mfbr_pkg.sv =====
// shared types, codes and constants of the msb-first bit reader
package mfbr_pkg;

	// default sizing
	localparam int BUFFER_BYTES_DEF   = 1024;
	localparam int MAX_FIELD_BITS_DEF = 32;

	// fixed field widths
	localparam int ACT_W  = 3;
	localparam int ADDR_W = 10;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 14;
	localparam int LEN_W  = 11;
	localparam int VAL_W  = 32;
	localparam int STS_W  = 2;

	// action codes
	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD = 3'd0,
		ACT_READ = 3'd1,
		ACT_PEEK = 3'd2,
		ACT_SKIP = 3'd3,
		ACT_SEEK = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [STS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_OVERRUN = 2'd2,
		ST_BOUNDS  = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic fetch;
		logic result;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_fetch;
		logic last_fetch;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/msb_first_bit_reader_unit.sv =====
// top level of the msb-first bit reader
// Reads bit fields most significant bit first from a byte store of BUFFER_BYTES entries. Load,
// skip, seek and rejected items go from acceptance straight to S_RESULT and the output register; a
// read or peek first passes through S_FETCH, one fetch per byte that the field touches, and S_WAIT,
// fetching through the single byte-wide read port of the store, which delivers one byte per cycle.
// One item is in progress at a time, and the next is accepted while the previous result still
// waits in the output register. The store has no reset; a byte must be loaded before it is read.
module msb_first_bit_reader_unit import mfbr_pkg::*; #(
	parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,   // byte_addr, byte_value, bit_amount
	input  logic [ACT_W-1:0]  s_axis_tuser,   // action
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [63:0]       m_axis_tdata,   // bits_value, position, remaining_bits, zero pad
	output logic [2:0]        m_axis_tuser,   // status, at_end
	input  logic              cfg_wr_en,
	input  logic [LEN_W-1:0]  cfg_wr_data     // buffer_length_bytes
);

	cmd_t              cmd;
	sts_t              sts;
	logic [STS_W-1:0]  status;
	logic [VAL_W-1:0]  bits_value;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  remaining_bits;
	logic              at_end;

	// controller
	mfbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	mfbr_dpath #(
		.BUFFER_BYTES   (BUFFER_BYTES),
		.MAX_FIELD_BITS (MAX_FIELD_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (s_axis_tuser),
		.byte_addr      (s_axis_tdata[9:0]),
		.byte_value     (s_axis_tdata[17:10]),
		.bit_amount     (s_axis_tdata[31:18]),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.m_tready       (m_axis_tready),
		.m_tvalid       (m_axis_tvalid),
		.status         (status),
		.bits_value     (bits_value),
		.position       (position),
		.remaining_bits (remaining_bits),
		.at_end         (at_end)
	);

	// result packing
	assign m_axis_tdata = {4'b0000, remaining_bits, position, bits_value};
	assign m_axis_tuser = {at_end, status};

endmodule

// ===== hw/rtl/mfbr_ctrl.sv =====
// controller state machine of the bit reader
`include "msb_first_bit_reader_unit_macros.svh"

module mfbr_ctrl import mfbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_WAIT,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = sts.need_fetch ? S_FETCH : S_RESULT;
				end
			end
			S_FETCH: begin
				if (sts.last_fetch) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	// command decode
	always_comb begin
		cmd.accept = ready_q && s_tvalid;
		cmd.fetch  = (state_q == S_FETCH);
		cmd.result = (state_q == S_RESULT) && sts.out_free;
	end

	assign s_tready = ready_q;

	`MFBR_ASSERT_NOW(a_ready_idle, 1'b1, ready_q == (state_q == S_IDLE))
	`MFBR_ASSERT_NEXT(a_fetch_follows, cmd.accept && sts.need_fetch, state_q == S_FETCH)
	`MFBR_ASSERT_NEXT(a_plain_to_result, cmd.accept && !sts.need_fetch, state_q == S_RESULT)

endmodule

// ===== hw/rtl/mfbr_dpath.sv =====
// datapath of the bit reader: byte store, position, fetch and output register
`include "msb_first_bit_reader_unit_macros.svh"

module mfbr_dpath import mfbr_pkg::*; #(
	parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [ACT_W-1:0]  action,
	input  logic [ADDR_W-1:0] byte_addr,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic [POS_W-1:0]  bit_amount,
	input  logic              cfg_wr_en,
	input  logic [LEN_W-1:0]  cfg_wr_data,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [STS_W-1:0]  status,
	output logic [VAL_W-1:0]  bits_value,
	output logic [POS_W-1:0]  position,
	output logic [POS_W-1:0]  remaining_bits,
	output logic              at_end
);

	localparam int AW     = $clog2(BUFFER_BYTES);
	localparam int NB     = (MAX_FIELD_BITS + 14) / 8;
	localparam int ACC_W  = 8 * NB;
	localparam int CNT_W  = $clog2(NB + 1);
	localparam int PTR_W  = POS_W - 3;

	logic [BYTE_W-1:0] store_q [BUFFER_BYTES];
	logic [BYTE_W-1:0] rdata_q;
	logic [LEN_W-1:0]  len_q;
	logic [POS_W-1:0]  pos_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2:0]        trail_q;
	logic [5:0]        n_q;
	logic              fetch_q;
	logic              rd_pend_q;
	logic [ACC_W-1:0]  acc_q;
	status_t           st_q;
	logic              m_valid_q;
	status_t           res_status_q;
	logic [VAL_W-1:0]  res_value_q;
	logic [POS_W-1:0]  res_pos_q;
	logic [POS_W-1:0]  res_rem_q;
	logic              res_end_q;

	logic [LEN_W-1:0]  len_sat;
	logic [POS_W-1:0]  total;
	logic [POS_W:0]    sum;
	logic              overrun;
	logic              bad_cnt;
	logic              seek_oob;
	status_t           st_d;
	logic              need_fetch;
	logic              pos_wr;
	logic [POS_W-1:0]  pos_d;
	logic [6:0]        span;
	logic [6:0]        trail_full;
	logic [CNT_W-1:0]  cnt_d;
	logic [VAL_W-1:0]  mask;
	logic [VAL_W-1:0]  extracted;
	logic [POS_W-1:0]  rem;

	// stream length in bits, saturated to the store size
	always_comb begin
		len_sat = len_q;
		if (32'(len_q) > BUFFER_BYTES) begin
			len_sat = LEN_W'(BUFFER_BYTES);
		end
		total = {len_sat, 3'b000};
	end

	// range checks on the incoming item
	assign sum      = {1'b0, pos_q} + {1'b0, bit_amount};
	assign overrun  = sum > {1'b0, total};
	assign bad_cnt  = (bit_amount == '0) || (32'(bit_amount) > MAX_FIELD_BITS);
	assign seek_oob = bit_amount > total;

	// status and position update per action
	always_comb begin
		st_d       = ST_OK;
		need_fetch = 1'b0;
		pos_wr     = 1'b0;
		pos_d      = sum[POS_W-1:0];
		case (action)
			ACT_READ, ACT_PEEK: begin
				if (bad_cnt) begin
					st_d = ST_INVALID;
				end else if (overrun) begin
					st_d = ST_OVERRUN;
				end else begin
					need_fetch = 1'b1;
					pos_wr     = (action == ACT_READ);
				end
			end
			ACT_SKIP: begin
				if (overrun) begin
					st_d = ST_OVERRUN;
				end else begin
					pos_wr = 1'b1;
				end
			end
			ACT_SEEK: begin
				if (seek_oob) begin
					st_d = ST_BOUNDS;
				end else begin
					pos_wr = 1'b1;
					pos_d  = bit_amount;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	// bytes touched by the field and bits left over after its last bit
	assign span       = 7'(pos_q[2:0]) + 7'(bit_amount[5:0]) + 7'd7;
	assign cnt_d      = CNT_W'(span[6:3]);
	assign trail_full = {span[6:3], 3'b000} - 7'(pos_q[2:0]) - 7'(bit_amount[5:0]);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	// read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept && pos_wr) begin
			pos_q <= pos_d;
		end
	end

	// byte store write on load
	always_ff @(posedge clk) begin
		if (cmd.accept && (action == ACT_LOAD) && (32'(byte_addr) < BUFFER_BYTES)) begin
			store_q[AW'(byte_addr)] <= byte_value;
		end
	end

	// byte store read, one byte per fetch cycle
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rdata_q <= store_q[AW'(ptr_q)];
		end
	end

	// fetch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_pend_q <= 1'b0;
			fetch_q   <= 1'b0;
			st_q      <= ST_OK;
		end else begin
			rd_pend_q <= cmd.fetch;
			if (cmd.accept) begin
				cnt_q   <= need_fetch ? cnt_d : '0;
				fetch_q <= need_fetch;
				st_q    <= st_d;
			end else if (cmd.fetch) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// field geometry and byte pointer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ptr_q   <= pos_q[POS_W-1:3];
			trail_q <= trail_full[2:0];
			n_q     <= bit_amount[5:0];
		end else if (cmd.fetch) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	// byte accumulator, oldest byte most significant
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			acc_q <= {acc_q[ACC_W-BYTE_W-1:0], rdata_q};
		end
	end

	// align and mask the field
	assign mask      = {VAL_W{1'b1}} >> (7'(VAL_W) - {1'b0, n_q});
	assign extracted = fetch_q ? (VAL_W'(acc_q >> trail_q) & mask) : '0;
	assign rem       = (pos_q >= total) ? '0 : total - pos_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.result) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			res_status_q <= st_q;
			res_value_q  <= extracted;
			res_pos_q    <= pos_q;
			res_rem_q    <= rem;
			res_end_q    <= (pos_q >= total);
		end
	end

	// status to controller
	always_comb begin
		sts.need_fetch = need_fetch;
		sts.last_fetch = (cnt_q == CNT_W'(1));
		sts.out_free   = !m_valid_q || m_tready;
	end

	assign m_tvalid       = m_valid_q;
	assign status         = res_status_q;
	assign bits_value     = res_value_q;
	assign position       = res_pos_q;
	assign remaining_bits = res_rem_q;
	assign at_end         = res_end_q;

	`MFBR_ASSERT_NOW(a_fetch_has_count, cmd.fetch, cnt_q != '0)
	`MFBR_ASSERT_NEXT(a_count_bound, cmd.accept && need_fetch, (cnt_q != '0) && (32'(cnt_q) <= NB))
	`MFBR_ASSERT_NOW(a_err_zero_value, m_valid_q && (res_status_q != ST_OK), res_value_q == '0)

endmodule
